// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define BLT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define BLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/blt_pkg.sv =====
// Package: shared constants, codes and types of the blitter.
package blt_pkg;

   localparam int SCREEN_W_DEF       = 128;
   localparam int SCREEN_H_DEF       = 32;
   localparam int SOURCE_H_DEF       = 64;
   localparam int GLYPH_W_DEF        = 5;
   localparam int GLYPH_H_DEF        = 8;
   localparam int GLYPHS_PER_ROW_DEF = 16;

   localparam int SRC_W   = 128;
   localparam int SRC_WPR = SRC_W / 32;

   // coordinate widths, signed, wide enough for the default parameter setting
   localparam int XW = 12;
   localparam int YW = 12;

   localparam logic [2:0] CMD_FILL   = 3'd0;
   localparam logic [2:0] CMD_BLIT   = 3'd1;
   localparam logic [2:0] CMD_CHAR   = 3'd2;
   localparam logic [2:0] CMD_ORIGIN = 3'd3;
   localparam logic [2:0] CMD_LOAD   = 3'd4;
   localparam logic [2:0] CMD_READ   = 3'd5;

   localparam logic [1:0] ROP_COPY = 2'd0;
   localparam logic [1:0] ROP_OR   = 2'd1;
   localparam logic [1:0] ROP_XOR  = 2'd2;
   localparam logic [1:0] ROP_ANDN = 2'd3;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_FIRST = 8'd33;
   localparam logic [7:0] CHAR_LAST  = 8'd126;

   localparam logic signed [10:0] CURSOR_X_MAX = 11'sd511;
   localparam logic signed [8:0]  CURSOR_Y_MAX = 9'sd127;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_PIX_RD,
      S_PIX_WR,
      S_RD,
      S_RD_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } walk_ctl_type;

endpackage

// ===== rtl/blt_walker.sv =====
// Region walker: column and row counters over a rectangle.
module blt_walker
   import blt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  walk_ctl_type ctl,
   input  logic [7:0]   width,
   input  logic [7:0]   height,
   output logic [7:0]   dx,
   output logic [7:0]   dy,
   output logic         last
);

   logic [7:0] dx_ff, dx_in, dy_ff, dy_in, w_ff, h_ff;
   logic       row_end;

   assign row_end = (dx_ff == w_ff - 8'd1);
   assign last    = row_end && (dy_ff == h_ff - 8'd1);
   assign dx      = dx_ff;
   assign dy      = dy_ff;

   always_comb begin
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (ctl.start) begin
         dx_in = '0;
         dy_in = '0;
      end else if (ctl.step) begin
         if (row_end) begin
            dx_in = '0;
            dy_in = dy_ff + 8'd1;
         end else begin
            dx_in = dx_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dx_ff <= '0;
         dy_ff <= '0;
      end else begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (ctl.start) begin
         w_ff <= width;
         h_ff <= height;
      end
   end

endmodule

// ===== rtl/blt_pix_unit.sv =====
// Shared pixel unit: clipping, word addresses and raster op for one pixel.
module blt_pix_unit
   import blt_pkg::*;
#(
   parameter int SCREEN_W = SCREEN_W_DEF,
   parameter int SCREEN_H = SCREEN_H_DEF,
   parameter int SOURCE_H = SOURCE_H_DEF,
   parameter int SCR_AW   = 7,
   parameter int SRC_AW   = 8
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic signed [XW-1:0] org_x,
   input  logic signed [YW-1:0] org_y,
   input  logic signed [XW-1:0] src_x0,
   input  logic signed [YW-1:0] src_y0,
   input  logic [7:0]           dx,
   input  logic [7:0]           dy,
   input  logic [1:0]           op,
   input  logic                 fill_bit,
   input  logic                 is_fill,
   input  logic [31:0]          scr_word,
   input  logic [31:0]          src_word,
   output logic [SCR_AW-1:0]    scr_raddr,
   output logic [SRC_AW-1:0]    src_raddr,
   output logic [SCR_AW-1:0]    scr_waddr,
   output logic                 wr_en,
   output logic [31:0]          wr_word
);

   localparam int SCR_WPR = (SCREEN_W + 31) / 32;
   localparam int LW      = XW + YW;

   logic signed [XW-1:0] px, sx;
   logic signed [YW-1:0] py, sy;
   logic [LW-1:0]        scr_lin, src_lin;
   logic                 on_scr, src_ok;
   logic                 on_scr_ff, src_ok_ff;
   logic [4:0]           scr_bit_ff, src_bit_ff;
   logic [SCR_AW-1:0]    scr_addr_ff;
   logic                 s_bit, d_bit, r_bit;

   assign px = org_x + $signed(XW'(dx));
   assign py = org_y + $signed(YW'(dy));
   assign sx = src_x0 + $signed(XW'(dx));
   assign sy = src_y0 + $signed(YW'(dy));

   assign on_scr = (px >= 0) && (px < $signed(XW'(SCREEN_W)))
                && (py >= 0) && (py < $signed(YW'(SCREEN_H)));
   assign src_ok = (sx >= 0) && (sx < $signed(XW'(SRC_W)))
                && (sy >= 0) && (sy < $signed(YW'(SOURCE_H)));

   assign scr_lin = LW'($unsigned(py)) * LW'(SCR_WPR) + LW'($unsigned(px[XW-1:5]));
   assign src_lin = LW'($unsigned(sy)) * LW'(SRC_WPR) + LW'($unsigned(sx[XW-1:5]));

   assign scr_raddr = scr_lin[SCR_AW-1:0];
   assign src_raddr = src_lin[SRC_AW-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         on_scr_ff   <= on_scr;
         src_ok_ff   <= src_ok;
         scr_bit_ff  <= px[4:0];
         src_bit_ff  <= sx[4:0];
         scr_addr_ff <= scr_raddr;
      end
   end

   assign s_bit = src_ok_ff & src_word[src_bit_ff];
   assign d_bit = scr_word[scr_bit_ff];

   always_comb begin
      if (is_fill) begin
         r_bit = fill_bit;
      end else begin
         unique case (op)
            ROP_OR:   r_bit = d_bit | s_bit;
            ROP_XOR:  r_bit = d_bit ^ s_bit;
            ROP_ANDN: r_bit = d_bit & ~s_bit;
            default:  r_bit = s_bit;
         endcase
      end
   end

   assign scr_waddr = scr_addr_ff;
   assign wr_en     = on_scr_ff;
   assign wr_word   = (scr_word & ~(32'd1 << scr_bit_ff)) | (32'(r_bit) << scr_bit_ff);

endmodule

// ===== rtl/monochrome_blitter_with_text_top.sv =====
// Top level: monochrome blitter with text, command sequencer and bit stores.
// Sequencing: fill, blit and printable characters visit each region pixel (a glyph is
//   GLYPH_W by GLYPH_H) in S_PIX_RD then S_PIX_WR; a read passes S_RD and S_RD_OUT,
//   and waits in S_RD_OUT while an earlier result is still held by a stall.
// Set origin, load, newline, fill or blit with an empty region and other codes finish in the accept cycle.
// The per-pixel read-modify-write through the screen store sets the rate.
// Reset: a clearing pass zeroes the screen word by word; req_stall holds.
module monochrome_blitter_with_text_top
   import blt_pkg::*;
#(
   parameter int SCREEN_W       = SCREEN_W_DEF,
   parameter int SCREEN_H       = SCREEN_H_DEF,
   parameter int SOURCE_H       = SOURCE_H_DEF,
   parameter int GLYPH_W        = GLYPH_W_DEF,
   parameter int GLYPH_H        = GLYPH_H_DEF,
   parameter int GLYPHS_PER_ROW = GLYPHS_PER_ROW_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic signed [8:0]  req_dst_x,
   input  logic signed [6:0]  req_dst_y,
   input  logic [7:0]         req_region_width,
   input  logic [7:0]         req_region_height,
   input  logic [6:0]         req_src_x,
   input  logic [5:0]         req_src_y,
   input  logic [1:0]         req_raster_op,
   input  logic               req_fill_bit,
   input  logic [7:0]         req_char_code,
   input  logic [7:0]         req_word_index,
   input  logic [31:0]        req_word_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_read_data
);

   localparam int SCR_WPR   = (SCREEN_W + 31) / 32;
   localparam int SCR_WORDS = SCR_WPR * SCREEN_H;
   localparam int SCR_AW    = $clog2(SCR_WORDS);
   localparam int SRC_WORDS = SRC_WPR * SOURCE_H;
   localparam int SRC_AW    = $clog2(SRC_WORDS);

   // ---------------- sequencer state ----------------
   state_type state_ff, state_in;
   logic [SCR_AW-1:0] clr_ff, clr_in;
   logic              accept, printable, region_ok, walk_last;

   // latched walk setup
   logic signed [XW-1:0] org_x_ff, sx0_ff;
   logic signed [YW-1:0] org_y_ff, sy0_ff;
   logic [1:0]           op_ff;
   logic                 fill_ff, is_fill_ff;
   logic                 rd_ok_ff;
   logic [SCR_AW-1:0]    rd_idx_ff;

   // text state
   logic signed [8:0] origin_x_ff, origin_x_in;
   logic signed [9:0] cursor_x_ff, cursor_x_in;
   logic signed [7:0] cursor_y_ff, cursor_y_in;
   logic signed [10:0] cx_adv;
   logic signed [8:0]  cy_adv;

   // glyph location in the atlas
   logic [6:0]           glyph_n, glyph_row, glyph_col;
   logic signed [XW-1:0] glyph_sx;
   logic signed [YW-1:0] glyph_sy;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic        rsp_load;

   // memories
   logic [31:0]       scr_mem [SCR_WORDS];
   logic [31:0]       src_mem [SRC_WORDS];
   logic [31:0]       scr_rdata_ff, src_rdata_ff;
   logic [SCR_AW-1:0] scr_raddr, scr_waddr, pix_scr_raddr, pix_scr_waddr;
   logic [SRC_AW-1:0] pix_src_raddr;
   logic              scr_we, pix_wr_en, src_we;
   logic [31:0]       scr_wdata, pix_wr_word;

   walk_ctl_type      walk_ctl;
   logic [7:0]        walk_w, walk_h, dx, dy;

   assign accept    = req_valid && !req_stall;
   assign printable = (req_char_code >= CHAR_FIRST) && (req_char_code <= CHAR_LAST);
   assign region_ok = (req_region_width != 8'd0) && (req_region_height != 8'd0);

   assign glyph_n   = 7'(req_char_code - CHAR_FIRST);

   // atlas row and column as a constant lookup over the glyph number
   always_comb begin
      glyph_row = '0;
      glyph_col = '0;
      for (int i = 0; i < 128; i++) begin
         if (glyph_n == 7'(i)) begin
            glyph_row = 7'(i / GLYPHS_PER_ROW);
            glyph_col = 7'(i % GLYPHS_PER_ROW);
         end
      end
   end

   assign glyph_sx  = $signed(XW'(glyph_col) * XW'(GLYPH_W));
   assign glyph_sy  = $signed(YW'(glyph_row) * YW'(GLYPH_H));

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (clr_ff == SCR_AW'(SCR_WORDS - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               priority case (req_command)
                  CMD_FILL, CMD_BLIT: if (region_ok) state_in = S_PIX_RD;
                  CMD_CHAR:           if (printable) state_in = S_PIX_RD;
                  CMD_READ:           state_in = S_RD;
                  default:            state_in = S_IDLE;
               endcase
            end
         end
         S_PIX_RD: state_in = S_PIX_WR;
         S_PIX_WR: state_in = walk_last ? S_IDLE : S_PIX_RD;
         S_RD:     state_in = S_RD_OUT;
         S_RD_OUT: if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_stall      = (state_ff != S_IDLE);
      walk_ctl.start = accept;
      walk_ctl.step  = (state_ff == S_PIX_WR);
      rsp_load       = (state_ff == S_RD_OUT) && (!rsp_valid_ff || !rsp_stall);
      clr_in         = (state_ff == S_CLEAR) ? clr_ff + SCR_AW'(1) : clr_ff;
      src_we         = accept && (req_command == CMD_LOAD)
                       && (32'(req_word_index) < 32'(SRC_WORDS));
      if (state_ff == S_CLEAR) begin
         scr_we    = 1'b1;
         scr_waddr = clr_ff;
         scr_wdata = '0;
      end else begin
         scr_we    = (state_ff == S_PIX_WR) && pix_wr_en;
         scr_waddr = pix_scr_waddr;
         scr_wdata = pix_wr_word;
      end
      if ((state_ff == S_RD) || (state_ff == S_RD_OUT)) begin
         scr_raddr = rd_idx_ff;
      end else begin
         scr_raddr = pix_scr_raddr;
      end
   end

   // width and height handed to the walker
   always_comb begin
      if (req_command == CMD_CHAR) begin
         walk_w = 8'(GLYPH_W);
         walk_h = 8'(GLYPH_H);
      end else begin
         walk_w = req_region_width;
         walk_h = req_region_height;
      end
   end

   // ---------------- text cursor ----------------
   assign cx_adv = 11'(cursor_x_ff) + 11'(GLYPH_W);
   assign cy_adv = 9'(cursor_y_ff) + 9'(GLYPH_H);

   always_comb begin
      origin_x_in = origin_x_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (accept && (req_command == CMD_ORIGIN)) begin
         origin_x_in = req_dst_x;
         cursor_x_in = 10'(req_dst_x);
         cursor_y_in = 8'(req_dst_y);
      end else if (accept && (req_command == CMD_CHAR) && (req_char_code != CHAR_NUL)) begin
         if (req_char_code == CHAR_NL) begin
            cursor_x_in = 10'(origin_x_ff);
            cursor_y_in = (cy_adv > CURSOR_Y_MAX) ? 8'(CURSOR_Y_MAX) : 8'(cy_adv);
         end else begin
            cursor_x_in = (cx_adv > CURSOR_X_MAX) ? 10'(CURSOR_X_MAX) : 10'(cx_adv);
         end
      end
   end

   // result channel: held until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         origin_x_ff  <= '0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         origin_x_ff  <= origin_x_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command setup, latched on accept, and the read result, latched on rsp_load
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_idx_ff  <= SCR_AW'(req_word_index);
         rd_ok_ff   <= (32'(req_word_index) < 32'(SCR_WORDS));
         fill_ff    <= req_fill_bit;
         is_fill_ff <= (req_command == CMD_FILL);
         if (req_command == CMD_CHAR) begin
            org_x_ff <= XW'(cursor_x_ff);
            org_y_ff <= YW'(cursor_y_ff);
            sx0_ff   <= glyph_sx;
            sy0_ff   <= glyph_sy;
            op_ff    <= (req_raster_op == ROP_COPY) ? ROP_OR : req_raster_op;
         end else begin
            org_x_ff <= XW'(req_dst_x);
            org_y_ff <= YW'(req_dst_y);
            sx0_ff   <= $signed(XW'(req_src_x));
            sy0_ff   <= $signed(YW'(req_src_y));
            op_ff    <= req_raster_op;
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= rd_ok_ff ? scr_rdata_ff : 32'd0;
      end
   end

   // screen store: one write, one registered read
   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_waddr] <= scr_wdata;
      end
      scr_rdata_ff <= scr_mem[scr_raddr];
   end

   // source store
   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[SRC_AW'(req_word_index)] <= req_word_data;
      end
      src_rdata_ff <= src_mem[pix_src_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // ---------------- datapath ----------------
   blt_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .ctl    (walk_ctl),
      .width  (walk_w),
      .height (walk_h),
      .dx     (dx),
      .dy     (dy),
      .last   (walk_last)
   );

   blt_pix_unit #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H),
      .SOURCE_H (SOURCE_H),
      .SCR_AW   (SCR_AW),
      .SRC_AW   (SRC_AW)
   ) u_pix (
      .clock     (clock),
      .load      (state_ff == S_PIX_RD),
      .org_x     (org_x_ff),
      .org_y     (org_y_ff),
      .src_x0    (sx0_ff),
      .src_y0    (sy0_ff),
      .dx        (dx),
      .dy        (dy),
      .op        (op_ff),
      .fill_bit  (fill_ff),
      .is_fill   (is_fill_ff),
      .scr_word  (scr_rdata_ff),
      .src_word  (src_rdata_ff),
      .scr_raddr (pix_scr_raddr),
      .src_raddr (pix_src_raddr),
      .scr_waddr (pix_scr_waddr),
      .wr_en     (pix_wr_en),
      .wr_word   (pix_wr_word)
   );

endmodule

// ===== rtl/blt_checker.sv =====
// Port checker for the blitter top level, with its bind.
`include "assert_macros.svh"

module blt_checker
   import blt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_read_data
);

   `BLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data), "stalled result changed")
   `BLT_ASSERT_NOW(a_clear_busy, $past(reset), req_stall, "accepting during screen clear")
   `BLT_ASSERT_NEXT(a_read_busy, req_valid && !req_stall && req_command == CMD_READ, req_stall, "read did not hold off input")
   `BLT_ASSERT_NEXT(a_no_spurious, req_valid && !req_stall && req_command != CMD_READ, !$rose(rsp_valid), "result without read")

endmodule

bind monochrome_blitter_with_text_top blt_checker u_blt_checker (.*);

// ===== dv/testbench.sv =====
// Testbench for the monochrome blitter: directed table, then random commands, checked by a predictor.
module testbench;
   import blt_pkg::*;

   localparam int N_RANDOM   = 1100;
   localparam int IDLE_LIMIT = 400000;  // largest fill is 255x255, with a read state and a write state per pixel
   localparam int SCR_WORDS  = 128;     // 128 x 32 screen, 4 words per row
   localparam int SRC_WORDS  = 256;     // 128 x 64 source

   typedef struct {
      logic [2:0]        cmd;
      logic signed [8:0] dx;
      logic signed [6:0] dy;
      logic [7:0]        w, h;
      logic [6:0]        sx;
      logic [5:0]        sy;
      logic [1:0]        op;
      logic              fb;
      logic [7:0]        ch, idx;
      logic [31:0]       data;
      bit                known;  // expected read data typed into the table
      logic [31:0]       want;
   } blt_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = CMD_READ;
   logic signed [8:0] req_dst_x = '0;
   logic signed [6:0] req_dst_y = '0;
   logic [7:0] req_region_width = '0, req_region_height = '0;
   logic [6:0] req_src_x = '0;
   logic [5:0] req_src_y = '0;
   logic [1:0] req_raster_op = ROP_COPY;
   logic req_fill_bit = 1'b0;
   logic [7:0] req_char_code = CHAR_NUL, req_word_index = '0;
   logic [31:0] req_word_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;

   monochrome_blitter_with_text_top u_top (.*);

   always #5 clock = ~clock;

   // predicted state of the block
   logic [31:0] screen_mem [SCR_WORDS];
   logic [31:0] sprite_mem [SRC_WORDS];
   int text_x0, cur_x, cur_y;

   logic [31:0] read_q [$];  // read data still owed by the block
   int errors = 0;
   int idle_cycles = 0;
   bit calm = 0;             // stretch with no gaps and no stalls
   int stall_left = 0;
   logic [31:0] got_word;
   blt_cmd_type table_q [$];

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic bit sprite_pix(int x, int y);
      if (x < 0 || x >= 128 || y < 0 || y >= 64) return 1'b0;
      return sprite_mem[y * 4 + x / 32][x % 32];
   endfunction

   function automatic bit on_screen(int x, int y);
      return x >= 0 && x < 128 && y >= 0 && y < 32;
   endfunction

   task automatic paint(int x, int y, int sx, int sy, int w, int h, logic [1:0] op,
                        bit is_fill, bit fb);
      bit s, d, r;
      for (int j = 0; j < h; j++)
         for (int i = 0; i < w; i++) begin
            if (!on_screen(x + i, y + j)) continue;
            d = screen_mem[(y + j) * 4 + (x + i) / 32][(x + i) % 32];
            s = sprite_pix(sx + i, sy + j);
            if (is_fill) r = fb;
            else case (op)
               ROP_OR:   r = d | s;
               ROP_XOR:  r = d ^ s;
               ROP_ANDN: r = d & ~s;
               default:  r = s;
            endcase
            screen_mem[(y + j) * 4 + (x + i) / 32][(x + i) % 32] = r;
         end
   endtask

   // updates the predicted state; returns 1 with the read data when a result is owed
   task automatic predict_cmd(blt_cmd_type c, output bit owed, output logic [31:0] val);
      int n;
      owed = 0;
      val = '0;
      case (c.cmd)
         CMD_FILL: paint(c.dx, c.dy, 0, 0, c.w, c.h, ROP_COPY, 1, c.fb);
         CMD_BLIT: paint(c.dx, c.dy, c.sx, c.sy, c.w, c.h, c.op, 0, 0);
         CMD_CHAR: begin
            if (c.ch == CHAR_NL) begin
               cur_x = text_x0;
               cur_y = (cur_y + 8 > 127) ? 127 : cur_y + 8;
            end else if (c.ch != CHAR_NUL) begin
               if (c.ch >= CHAR_FIRST && c.ch <= CHAR_LAST) begin
                  n = c.ch - CHAR_FIRST;
                  paint(cur_x, cur_y, (n % 16) * 5, (n / 16) * 8, 5, 8,
                        (c.op == ROP_COPY) ? ROP_OR : c.op, 0, 0);
               end
               cur_x = (cur_x + 5 > 511) ? 511 : cur_x + 5;
            end
         end
         CMD_ORIGIN: begin
            text_x0 = c.dx;
            cur_x = c.dx;
            cur_y = c.dy;
         end
         CMD_LOAD: sprite_mem[c.idx] = c.data;
         CMD_READ: begin
            owed = 1;
            val = (c.idx < SCR_WORDS) ? screen_mem[c.idx] : '0;
         end
         default: ;
      endcase
   endtask

   task automatic send(blt_cmd_type c);
      bit owed;
      logic [31:0] val;
      int gap;
      req_valid <= 1'b1;
      req_command <= c.cmd;
      req_dst_x <= c.dx;
      req_dst_y <= c.dy;
      req_region_width <= c.w;
      req_region_height <= c.h;
      req_src_x <= c.sx;
      req_src_y <= c.sy;
      req_raster_op <= c.op;
      req_fill_bit <= c.fb;
      req_char_code <= c.ch;
      req_word_index <= c.idx;
      req_word_data <= c.data;
      do @(posedge clock); while (req_stall);
      predict_cmd(c, owed, val);
      if (owed) read_q.push_back(c.known ? c.want : val);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic blt_cmd_type rand_cmd(logic [2:0] cmd);
      blt_cmd_type c;
      int r;
      c.cmd = cmd;
      c.dx = 9'($urandom);
      c.dy = 7'($urandom);
      c.sx = 7'($urandom);
      c.sy = 6'($urandom);
      c.op = 2'($urandom);
      c.fb = 1'($urandom);
      c.ch = 8'($urandom);
      c.idx = 8'($urandom);
      c.data = $urandom;
      c.known = 0;
      c.want = '0;
      // mostly small regions; now and then one long side to reach the high bits
      r = $urandom_range(0, 99);
      c.w = 8'($urandom_range(0, 14));
      c.h = 8'($urandom_range(0, 14));
      if (r < 2) begin
         c.w = 8'($urandom_range(128, 255));
         c.h = 8'($urandom_range(1, 2));
      end else if (r < 4) begin
         c.h = 8'($urandom_range(128, 255));
         c.w = 8'($urandom_range(1, 2));
      end else if (r < 20) begin
         c.dx = 9'($signed($urandom_range(0, 140)) - 10);
         c.dy = 7'($signed($urandom_range(0, 40)) - 4);
      end
      if (cmd == CMD_CHAR) begin
         r = $urandom_range(0, 99);
         if (r < 70) c.ch = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
         else if (r < 82) c.ch = CHAR_NL;
         else if (r < 87) c.ch = CHAR_NUL;
      end
      return c;
   endfunction

   function automatic blt_cmd_type row(logic [2:0] cmd, int dx, int dy, int w, int h, int sx,
                                    int sy, logic [1:0] op, bit fb, logic [7:0] ch, int idx,
                                    bit known, logic [31:0] want);
      blt_cmd_type c;
      c = rand_cmd(cmd);
      c.dx = 9'(dx); c.dy = 7'(dy); c.w = 8'(w); c.h = 8'(h); c.sx = 7'(sx); c.sy = 6'(sy);
      c.op = op; c.fb = fb; c.ch = ch; c.idx = 8'(idx);
      c.known = known; c.want = want;
      return c;
   endfunction

   // checks the read data and drives the result-side stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (read_q.size() == 0) report("read data with no read pending");
         else begin
            got_word = read_q.pop_front();
            if (rsp_read_data !== got_word)
               report($sformatf("read_data %h, expected %h", rsp_read_data, got_word));
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      blt_cmd_type c;
      int run;
      for (int i = 0; i < SCR_WORDS; i++) screen_mem[i] = '0;
      text_x0 = 0;
      cur_x = 0;
      cur_y = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // screen reads right after reset, including past the last word
      table_q.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 0, 0, 1, '0));
      table_q.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 0, 127, 1, '0));
      table_q.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 0, 128, 1, '0));
      table_q.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 0, 255, 1, '0));
      foreach (table_q[i]) send(table_q[i]);
      table_q.delete();

      // every source word written before any blit or glyph can read it
      for (int i = 0; i < SRC_WORDS; i++) begin
         c = rand_cmd(CMD_LOAD);
         c.idx = 8'(i);
         if (i == 0) c.data = '1;
         send(c);
      end

      // largest fill from a negative corner covers the screen
      table_q.push_back(row(CMD_FILL, -64, -64, 255, 255, 0, 0, ROP_COPY, 1, 0, 0, 0, 0));
      table_q.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 0, 0, 1, '1));
      table_q.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 0, 127, 1, '1));
      table_q.push_back(row(CMD_FILL, 120, 30, 20, 5, 0, 0, ROP_COPY, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_FILL, 255, 63, 0, 9, 0, 0, ROP_COPY, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_BLIT, 0, 0, 40, 3, 0, 0, ROP_COPY, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_BLIT, -5, 10, 20, 6, 120, 60, ROP_OR, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_BLIT, 100, 20, 30, 4, 127, 0, ROP_XOR, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_BLIT, 10, -3, 12, 8, 0, 63, ROP_ANDN, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_BLIT, 3, 3, 5, 0, 0, 0, ROP_XOR, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_ORIGIN, 2, 1, 0, 0, 0, 0, ROP_COPY, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_CHAR, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, CHAR_FIRST, 0, 0, 0));
      table_q.push_back(row(CMD_CHAR, 0, 0, 0, 0, 0, 0, ROP_XOR, 0, CHAR_LAST, 0, 0, 0));
      table_q.push_back(row(CMD_CHAR, 0, 0, 0, 0, 0, 0, ROP_ANDN, 0, CHAR_NUL, 0, 0, 0));
      table_q.push_back(row(CMD_CHAR, 0, 0, 0, 0, 0, 0, ROP_OR, 0, 8'd200, 0, 0, 0));
      table_q.push_back(row(CMD_CHAR, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, CHAR_NL, 0, 0, 0));
      table_q.push_back(row(CMD_CHAR, 0, 0, 0, 0, 0, 0, ROP_ANDN, 0, 8'd65, 0, 0, 0));
      table_q.push_back(row(CMD_ORIGIN, 255, 63, 0, 0, 0, 0, ROP_COPY, 0, 0, 0, 0, 0));
      table_q.push_back(row(CMD_CHAR, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 8'd90, 0, 0, 0));
      table_q.push_back(row(3'd6, 0, 0, 9, 9, 0, 0, ROP_COPY, 1, 0, 0, 0, 0));
      table_q.push_back(row(3'd7, 0, 0, 9, 9, 0, 0, ROP_COPY, 1, 0, 0, 0, 0));
      table_q.push_back(row(CMD_READ, 0, 0, 0, 0, 0, 0, ROP_COPY, 0, 0, 4, 0, 0));
      foreach (table_q[i]) send(table_q[i]);

      // hold the sender until every read has come back
      req_valid <= 1'b0;
      while (read_q.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 600 && n < 750);
         if ($urandom_range(0, 99) < 12) begin
            // a line of text: origin, then a run of characters
            c = rand_cmd(CMD_ORIGIN);
            if ($urandom_range(0, 3) != 0) begin
               c.dx = 9'($signed($urandom_range(0, 130)) - 8);
               c.dy = 7'($signed($urandom_range(0, 36)) - 6);
            end
            send(c);
            run = $urandom_range(4, 24);
            for (int k = 0; k < run; k++) send(rand_cmd(CMD_CHAR));
            n += run;
         end else begin
            case ($urandom_range(0, 19))
               0, 1:           c = rand_cmd(CMD_LOAD);
               2, 3, 4, 5:     c = rand_cmd(CMD_READ);
               6, 7, 8:        c = rand_cmd(CMD_FILL);
               9, 10, 11, 12:  c = rand_cmd(CMD_BLIT);
               13, 14, 15, 16: c = rand_cmd(CMD_CHAR);
               17:             c = rand_cmd(CMD_ORIGIN);
               default:        c = rand_cmd(3'($urandom_range(6, 7)));
            endcase
            send(c);
         end
      end
      send(rand_cmd(CMD_READ));
      req_valid <= 1'b0;

      while (read_q.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
